FILE: src/c8df_pkg.sv
// ----------------------------------------------------------------------------
// c8df_pkg - shared definitions for the CRC-8 packet deframer
// Phase and event codes, configuration indexes, reset values, CRC-8 update.
// ----------------------------------------------------------------------------
`default_nettype none

package c8df_pkg;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

  // Configuration reset values
  localparam logic [BYTE_W-1:0]  START_BYTE_RST = 8'hD5;
  localparam logic [TICKS_W-1:0] TIMEOUT_RST    = 16'd1000;

  // Reflected Dallas/Maxim polynomial
  localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_CRC  = 2'd3
  } phase_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_CRCERR  = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

  // One byte folded into a reflected CRC-8, LSB first
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] v;
    v = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/c8df_if.sv
// ----------------------------------------------------------------------------
// c8df_if - request channels of the CRC-8 packet deframer
// Input channel (byte or tick) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface c8df_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [c8df_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface c8df_out_if;
  logic                          valid;
  logic                          ready;
  logic [c8df_pkg::EVENT_W-1:0]  event_res;
  logic [c8df_pkg::BYTE_W-1:0]   payload;

  modport source (output valid, output event_res, output payload, input ready);
  modport sink   (input valid, input event_res, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/crc8_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// crc8_packet_deframer_top - length-prefixed packet deframer with CRC-8 check
// Start byte, length byte, payload bytes, CRC byte; idle-tick timeout.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Payload
//  rx_i      in   valid/ready   opcode, rx_byte
//  res_o     out  valid/ready   event_res, payload
//  cfg_*     in   write enable  cfg_idx_i, cfg_data_i
//
//  One request per cycle; any result of a request is written into the result register.
//  Requests are taken while the result register is empty or being drained.
//  The frame state and the CRC update sit between input and result register.
//  Reset clears phase, counters and the result valid; config returns to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_packet_deframer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  c8df_in_if.sink                                rx_i,
  c8df_out_if.source                             res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [c8df_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [c8df_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Configuration registers
  logic [c8df_pkg::BYTE_W-1:0]  start_byte_q;
  logic [c8df_pkg::TICKS_W-1:0] timeout_q;

  // Frame state
  c8df_pkg::phase_e             phase_q, phase_d;
  logic [c8df_pkg::BYTE_W-1:0]  remaining_q, remaining_d;
  logic [c8df_pkg::BYTE_W-1:0]  crc_q, crc_d;
  logic [c8df_pkg::TICKS_W-1:0] ticks_q, ticks_d;

  // Result register
  logic                         res_valid_q, res_valid_d;
  c8df_pkg::event_e             res_event_q, res_event_d;
  logic [c8df_pkg::BYTE_W-1:0]  res_payload_q, res_payload_d;

  logic                         in_fire;
  logic                         is_tick;
  logic [c8df_pkg::TICKS_W-1:0] ticks_inc;
  logic                         tick_expire;
  logic [c8df_pkg::BYTE_W-1:0]  crc_next;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign is_tick    = (rx_i.opcode == c8df_pkg::OP_TICK);

  // Saturating idle-tick count and timeout compare
  assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign tick_expire = (ticks_inc > timeout_q);

  assign crc_next = c8df_pkg::crc8_update(crc_q, rx_i.rx_byte);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= c8df_pkg::START_BYTE_RST;
      timeout_q    <= c8df_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        c8df_pkg::CFG_START_BYTE: start_byte_q <= cfg_data_i[c8df_pkg::BYTE_W-1:0];
        c8df_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next frame state
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    crc_d       = crc_q;
    ticks_d     = ticks_q;
    if (in_fire) begin
      if (is_tick) begin
        if (phase_q != c8df_pkg::PH_IDLE) begin
          if (tick_expire) begin
            phase_d = c8df_pkg::PH_IDLE;
            ticks_d = '0;
          end else begin
            ticks_d = ticks_inc;
          end
        end
      end else begin
        ticks_d = '0;
        unique case (phase_q)
          c8df_pkg::PH_IDLE: begin
            if (rx_i.rx_byte == start_byte_q) begin
              phase_d = c8df_pkg::PH_LEN;
            end
          end
          c8df_pkg::PH_LEN: begin
            remaining_d = rx_i.rx_byte;
            crc_d       = '0;
            phase_d     = c8df_pkg::PH_PAY;
          end
          c8df_pkg::PH_PAY: begin
            crc_d       = crc_next;
            remaining_d = remaining_q - 1'b1;
            // a count of one left (or zero meaning 256 wrapped down) ends payload
            if (remaining_q == c8df_pkg::BYTE_W'(1)) begin
              phase_d = c8df_pkg::PH_CRC;
            end
          end
          c8df_pkg::PH_CRC: begin
            phase_d = c8df_pkg::PH_IDLE;
          end
          default: phase_d = c8df_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Next result
  always_comb begin
    res_valid_d   = res_valid_q && !res_o.ready;
    res_event_d   = res_event_q;
    res_payload_d = res_payload_q;
    if (in_fire) begin
      res_valid_d   = 1'b0;
      res_payload_d = '0;
      if (is_tick) begin
        if ((phase_q != c8df_pkg::PH_IDLE) && tick_expire) begin
          res_valid_d = 1'b1;
          res_event_d = c8df_pkg::EV_TIMEOUT;
        end
      end else begin
        unique case (phase_q)
          c8df_pkg::PH_PAY: begin
            res_valid_d   = 1'b1;
            res_event_d   = c8df_pkg::EV_PAYLOAD;
            res_payload_d = rx_i.rx_byte;
          end
          c8df_pkg::PH_CRC: begin
            res_valid_d = 1'b1;
            res_event_d = (crc_q == rx_i.rx_byte) ? c8df_pkg::EV_GOOD
                                                  : c8df_pkg::EV_CRCERR;
          end
          default: ;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= c8df_pkg::PH_IDLE;
      remaining_q <= '0;
      crc_q       <= '0;
      ticks_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      crc_q       <= crc_d;
      ticks_q     <= ticks_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    res_event_q   <= res_event_d;
    res_payload_q <= res_payload_d;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.event_res = res_event_q;
  assign res_o.payload   = res_payload_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // no open frame means no pending idle ticks
  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == c8df_pkg::PH_IDLE |-> ticks_q == '0)
    else $error("idle tick count nonzero while no frame is open");

  // a received byte always clears the idle-tick count
  a_byte_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_tick |=> ticks_q == '0)
    else $error("byte did not clear idle tick count");

  // a timeout result leaves the block idle
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_tick && res_valid_d && res_event_d == c8df_pkg::EV_TIMEOUT
    |=> phase_q == c8df_pkg::PH_IDLE)
    else $error("timeout did not close the frame");

  // only payload events carry data
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_event_q != c8df_pkg::EV_PAYLOAD |-> res_payload_q == '0)
    else $error("non-payload result carries data");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> res_valid_q && !res_o.ready)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

FILE: tb/crc8_packet_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// crc8_packet_deframer_top_tb - self-checking testbench for the CRC-8 deframer
// Drives bytes and ticks over the request channel with random gaps and stalls
// on the result channel. A behavioral copy of the deframer predicts every
// event, which is compared field by field with the results in order.
// Directed tests cover reset defaults, start byte values, length extremes and
// the idle-tick timeout; a random phase mixes frames, noise and aborts.
// ----------------------------------------------------------------------------

module crc8_packet_deframer_top_tb;

  import c8df_pkg::*;

  localparam int unsigned MAX_WAIT      = 5;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned SETTLE_CYCLES = 3;
  localparam int unsigned LONG_TICKS    = 40;
  localparam longint     WATCHDOG_TIME = 64'd24_000_000;

  typedef struct packed {
    event_e             ev;
    logic [BYTE_W-1:0]  data;
  } deframe_event_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_START_BYTE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  c8df_in_if  rx_if ();
  c8df_out_if res_if ();

  crc8_packet_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the deframer: configuration and frame state
  logic [BYTE_W-1:0]  shadow_start;
  logic [TICKS_W-1:0] shadow_timeout;
  phase_e             shadow_phase;
  logic [BYTE_W-1:0]  shadow_left;
  logic [BYTE_W-1:0]  shadow_crc;
  logic [TICKS_W-1:0] shadow_idle;

  deframe_event_t pending_events[$];
  int unsigned    error_cnt      = 0;
  int unsigned    frame_item_cnt = 0;
  int unsigned    ready_hold     = 0;
  bit             sender_burst   = 1'b0;
  bit             receiver_burst = 1'b0;

  // Reflected CRC-8, one data bit at a time, LSB first
  function automatic logic [BYTE_W-1:0] crc8_maxim_fold(input logic [BYTE_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] c;
    logic              mix;
    c = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      mix = c[0] ^ d[i];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  // Advance the shadow deframer by one accepted request, queue its event
  task automatic deframe_step(input logic op, input logic [BYTE_W-1:0] b);
    deframe_event_t ev;
    bit             fired;
    bit             counted;
    fired   = 1'b0;
    counted = 1'b1;
    if (op == OP_TICK) begin
      if (shadow_phase == PH_IDLE) begin
        counted = 1'b0;
      end else begin
        if (shadow_idle != 16'hFFFF) begin
          shadow_idle = shadow_idle + 16'd1;
        end
        if (shadow_idle > shadow_timeout) begin
          shadow_phase = PH_IDLE;
          shadow_idle  = '0;
          ev           = '{EV_TIMEOUT, 8'h00};
          fired        = 1'b1;
        end
      end
    end else begin
      shadow_idle = '0;
      case (shadow_phase)
        PH_IDLE: begin
          if (b == shadow_start) begin
            shadow_phase = PH_LEN;
          end else begin
            counted = 1'b0;
          end
        end
        PH_LEN: begin
          shadow_left  = b;
          shadow_crc   = '0;
          shadow_phase = PH_PAY;
        end
        PH_PAY: begin
          shadow_crc  = crc8_maxim_fold(shadow_crc, b);
          shadow_left = shadow_left - 8'd1;
          if (shadow_left == 8'd0) begin
            shadow_phase = PH_CRC;
          end
          ev    = '{EV_PAYLOAD, b};
          fired = 1'b1;
        end
        default: begin
          shadow_phase = PH_IDLE;
          ev           = '{(shadow_crc == b) ? EV_GOOD : EV_CRCERR, 8'h00};
          fired        = 1'b1;
        end
      endcase
    end
    if (fired) begin
      pending_events.push_back(ev);
    end
    if (counted) begin
      frame_item_cnt++;
    end
  endtask

  // Send one request after a random gap and wait for its acceptance
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.opcode  <= op;
    rx_if.rx_byte <= b;
    do begin
      @(posedge clk_i);
    end while (!rx_if.ready);
    deframe_step(op, b);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write while the block is quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      CFG_START_BYTE: shadow_start   = value[BYTE_W-1:0];
      CFG_TIMEOUT:    shadow_timeout = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Full frame: start, length, n payload bytes (fill < 0 means random), CRC.
  // tick_pct is the chance of a tick burst ahead of each payload byte.
  task automatic send_frame(input int n, input bit bad_crc, input int fill, input int tick_pct);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    int unsigned       burst_len;
    send_byte(shadow_start);
    send_byte(n[7:0]);
    crc = '0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        burst_len = (shadow_timeout <= 8) ? $urandom_range(1, shadow_timeout + 1)
                                          : $urandom_range(1, 3);
        repeat (burst_len) send_tick();
      end
      b   = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      crc = crc8_maxim_fold(crc, b);
      send_byte(b);
    end
    if (bad_crc) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(crc);
  endtask

  // Result side: random stalls, in-order compare against the shadow
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      res_if.ready <= 1'b0;
      ready_hold--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deframe_event_t exp_ev;
    if (rst_ni && res_if.valid && res_if.ready) begin
      ready_hold = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (pending_events.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result: expected none, actual event %0d payload 0x%02h",
                 $time, res_if.event_res, res_if.payload);
      end else begin
        exp_ev = pending_events.pop_front();
        if (res_if.event_res !== exp_ev.ev) begin
          error_cnt++;
          $display("%0t: event mismatch: expected %0d (%s), actual %0d",
                   $time, exp_ev.ev, exp_ev.ev.name(), res_if.event_res);
        end
        if (res_if.payload !== exp_ev.data) begin
          error_cnt++;
          $display("%0t: payload mismatch: expected 0x%02h, actual 0x%02h",
                   $time, exp_ev.data, res_if.payload);
        end
      end
    end
  end

  // Reset values: idle ticks and stray bytes are dropped, default start byte
  task automatic test_reset_defaults();
    send_tick();
    send_byte(8'h00);
    send_frame(1, 1'b0, 0, 0);
    send_frame(2, 1'b1, 255, 0);
    send_frame(3, 1'b0, -1, 0);
  endtask

  // Start byte extremes, and the start value showing up inside a frame
  task automatic test_start_byte_values();
    write_reg(CFG_START_BYTE, 16'h0000);
    send_byte(8'hFF);
    send_frame(3, 1'b0, 0, 0);
    write_reg(CFG_START_BYTE, 16'h00FF);
    send_frame(4, 1'b1, 255, 0);
    send_frame(2, 1'b0, -1, 0);
    write_reg(CFG_START_BYTE, 16'h0003);
    send_frame(3, 1'b0, 3, 0);
    write_reg(CFG_START_BYTE, {8'h00, START_BYTE_RST});
  endtask

  // Longest explicit length and the zero length that wraps to 256
  task automatic test_length_extremes();
    send_frame(255, 1'b0, -1, 0);
    send_frame(256, 1'b0, -1, 0);
    send_frame(256, 1'b1, -1, 0);
  endtask

  // Idle-tick timeout: zero limit, clearing by bytes, limit changed mid-frame
  task automatic test_idle_timeout();
    write_reg(CFG_TIMEOUT, 16'd0);
    send_tick();
    send_byte(shadow_start);
    send_tick();
    send_byte(shadow_start);
    send_byte(8'd3);
    send_byte(8'hA5);
    send_tick();

    write_reg(CFG_TIMEOUT, 16'd1);
    send_byte(shadow_start);
    send_byte(8'd2);
    send_tick();
    send_byte(8'h5A);
    send_tick();
    send_tick();
    send_frame(2, 1'b0, -1, 40);

    // Limit at maximum: a long run of ticks never trips
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_byte(shadow_start);
    send_byte(8'd1);
    sender_burst = 1'b1;
    repeat (LONG_TICKS) send_tick();
    sender_burst = 1'b0;
    // Lowering the limit under the running count aborts on the next tick
    write_reg(CFG_TIMEOUT, 16'd10);
    send_tick();
    write_reg(CFG_TIMEOUT, TIMEOUT_RST);
  endtask

  // Mostly well-formed frames with random content, plus noise and aborts
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned sel;
    int unsigned pick;
    int          n;
    int          k;
    target = frame_item_cnt + RANDOM_ITEMS;
    while (frame_item_cnt < target) begin
      if ($urandom_range(0, 19) == 0) begin
        sender_burst = ~sender_burst;
      end
      if ($urandom_range(0, 19) == 0) begin
        receiver_burst = ~receiver_burst;
      end
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        // new register setting
        pick = $urandom_range(0, 2);
        if (pick != 1) begin
          case ($urandom_range(0, 9))
            0:       write_reg(CFG_START_BYTE, 16'h0000);
            1:       write_reg(CFG_START_BYTE, 16'h00FF);
            default: write_reg(CFG_START_BYTE, 16'($urandom_range(0, 255)));
          endcase
        end
        if (pick != 0) begin
          case ($urandom_range(0, 5))
            0:       write_reg(CFG_TIMEOUT, 16'd1);
            1:       write_reg(CFG_TIMEOUT, 16'd2);
            2:       write_reg(CFG_TIMEOUT, 16'($urandom_range(3, 8)));
            3:       write_reg(CFG_TIMEOUT, 16'($urandom_range(9, 40)));
            4:       write_reg(CFG_TIMEOUT, 16'hFFFF);
            default: write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 65535)));
          endcase
        end
      end else if (sel < 12) begin
        // line noise
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) begin
            send_tick();
          end else begin
            send_byte(8'($urandom_range(0, 255)));
          end
        end
      end else if (sel < 22 && shadow_timeout <= 16) begin
        // frame cut short and aborted by the timeout
        n = $urandom_range(2, 10);
        k = $urandom_range(0, n - 1);
        send_byte(shadow_start);
        send_byte(n[7:0]);
        repeat (k) send_byte(8'($urandom_range(0, 255)));
        repeat (shadow_timeout + 1) send_tick();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          n = 256;
        end else if (pick < 5) begin
          n = $urandom_range(128, 255);
        end else begin
          n = $urandom_range(1, 8);
        end
        send_frame(n, $urandom_range(0, 4) == 0, -1, 15);
      end
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  initial begin
    rx_if.valid    = 1'b0;
    rx_if.opcode   = OP_BYTE;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    shadow_start   = START_BYTE_RST;
    shadow_timeout = TIMEOUT_RST;
    shadow_phase   = PH_IDLE;
    shadow_left    = '0;
    shadow_crc     = '0;
    shadow_idle    = '0;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_start_byte_values();
    test_length_extremes();
    test_idle_timeout();
    test_random_traffic();

    drain_results();
    if (error_cnt == 0) begin
      $display("crc8_packet_deframer_top verification clean");
    end else begin
      $display("crc8_packet_deframer_top verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(WATCHDOG_TIME);
    $display("crc8_packet_deframer_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
src/c8df_pkg.sv
src/c8df_if.sv
src/crc8_packet_deframer_top.sv
tb/crc8_packet_deframer_top_tb.sv
